/* rtl/core/assert_macros.svh */
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle, off during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition checked at every edge, reset included
`define AST_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

`endif

/* rtl/core/mpse_pkg.sv */
// shared types and constants of the messagepack scalar encoder
// no dependencies
`timescale 1ns / 1ps

package mpse_pkg;

    localparam int ACTION_W    = 4;
    localparam int OPERAND_W   = 64;
    localparam int BYTE_W      = 8;
    localparam int NBYTES_W    = 4;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NIL     = 4'd0,
        ACT_BOOL    = 4'd1,
        ACT_UINT    = 4'd2,
        ACT_SINT    = 4'd3,
        ACT_FLOAT32 = 4'd4,
        ACT_FLOAT64 = 4'd5,
        ACT_STR_HDR = 4'd6,
        ACT_BIN_HDR = 4'd7,
        ACT_RAW     = 4'd8
    } action_t;

    localparam logic [BYTE_W-1:0] PFX_NIL     = 8'hc0;
    localparam logic [BYTE_W-1:0] PFX_FALSE   = 8'hc2;
    localparam logic [BYTE_W-1:0] PFX_TRUE    = 8'hc3;
    localparam logic [BYTE_W-1:0] PFX_BIN8    = 8'hc4;
    localparam logic [BYTE_W-1:0] PFX_BIN16   = 8'hc5;
    localparam logic [BYTE_W-1:0] PFX_BIN32   = 8'hc6;
    localparam logic [BYTE_W-1:0] PFX_FLOAT32 = 8'hca;
    localparam logic [BYTE_W-1:0] PFX_FLOAT64 = 8'hcb;
    localparam logic [BYTE_W-1:0] PFX_UINT8   = 8'hcc;
    localparam logic [BYTE_W-1:0] PFX_UINT16  = 8'hcd;
    localparam logic [BYTE_W-1:0] PFX_UINT32  = 8'hce;
    localparam logic [BYTE_W-1:0] PFX_UINT64  = 8'hcf;
    localparam logic [BYTE_W-1:0] PFX_INT8    = 8'hd0;
    localparam logic [BYTE_W-1:0] PFX_INT16   = 8'hd1;
    localparam logic [BYTE_W-1:0] PFX_INT32   = 8'hd2;
    localparam logic [BYTE_W-1:0] PFX_INT64   = 8'hd3;
    localparam logic [BYTE_W-1:0] PFX_STR8    = 8'hd9;
    localparam logic [BYTE_W-1:0] PFX_STR16   = 8'hda;
    localparam logic [BYTE_W-1:0] PFX_STR32   = 8'hdb;
    localparam logic [BYTE_W-1:0] PFX_FIXSTR  = 8'ha0;
    localparam logic [BYTE_W-1:0] PFX_ERROR   = 8'h00;

    // one classified element: first byte, then nbytes payload bytes from the top
    typedef struct packed {
        logic [BYTE_W-1:0]    prefix;
        logic [NBYTES_W-1:0]  nbytes;
        logic [OPERAND_W-1:0] payload;
        logic                 err;
    } desc_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_PREFIX,
        EMIT_PAYLOAD
    } emit_state_t;

endpackage

/* rtl/core/mpse_classify.sv */
// front end: takes requests and turns each known action into an element descriptor
// depends on mpse_pkg
`timescale 1ns / 1ps

module mpse_classify
    import mpse_pkg::*;
(
    input  logic                 push,
    input  logic                 full,
    input  logic [ACTION_W-1:0]  action,
    input  logic [OPERAND_W-1:0] operand,
    output logic                 wr_en,
    output desc_t                wr_desc
);

    logic [BYTE_W-1:0]   cls_prefix;
    logic [NBYTES_W-1:0] cls_n;
    logic                cls_err;
    logic                known;

    always_comb
    begin
        cls_prefix = operand[7:0];
        cls_n      = 4'd0;
        cls_err    = 1'b0;
        known      = 1'b1;
        unique case (action_t'(action))
            ACT_NIL:     cls_prefix = PFX_NIL;
            ACT_BOOL:    cls_prefix = (operand != '0) ? PFX_TRUE : PFX_FALSE;
            ACT_UINT:
            begin
                priority if (operand[63:7] == '0)
                    cls_prefix = operand[7:0];
                else if (operand[63:8] == '0)
                begin
                    cls_prefix = PFX_UINT8;
                    cls_n      = 4'd1;
                end
                else if (operand[63:16] == '0)
                begin
                    cls_prefix = PFX_UINT16;
                    cls_n      = 4'd2;
                end
                else if (operand[63:32] == '0)
                begin
                    cls_prefix = PFX_UINT32;
                    cls_n      = 4'd4;
                end
                else
                begin
                    cls_prefix = PFX_UINT64;
                    cls_n      = 4'd8;
                end
            end
            ACT_SINT:
            begin
                if (!operand[63])
                begin
                    priority if (operand[63:7] == '0)
                        cls_prefix = operand[7:0];
                    else if (operand[63:15] == '0)
                    begin
                        cls_prefix = PFX_INT16;
                        cls_n      = 4'd2;
                    end
                    else if (operand[63:31] == '0)
                    begin
                        cls_prefix = PFX_INT32;
                        cls_n      = 4'd4;
                    end
                    else
                    begin
                        cls_prefix = PFX_INT64;
                        cls_n      = 4'd8;
                    end
                end
                else
                begin
                    priority if (&operand[63:5])
                        cls_prefix = operand[7:0];
                    else if (&operand[63:7])
                    begin
                        cls_prefix = PFX_INT8;
                        cls_n      = 4'd1;
                    end
                    else if (&operand[63:15])
                    begin
                        cls_prefix = PFX_INT16;
                        cls_n      = 4'd2;
                    end
                    else if (&operand[63:31])
                    begin
                        cls_prefix = PFX_INT32;
                        cls_n      = 4'd4;
                    end
                    else
                    begin
                        cls_prefix = PFX_INT64;
                        cls_n      = 4'd8;
                    end
                end
            end
            ACT_FLOAT32:
            begin
                cls_prefix = PFX_FLOAT32;
                cls_n      = 4'd4;
            end
            ACT_FLOAT64:
            begin
                cls_prefix = PFX_FLOAT64;
                cls_n      = 4'd8;
            end
            ACT_STR_HDR, ACT_BIN_HDR:
            begin
                priority if (action_t'(action) == ACT_STR_HDR && operand[63:5] == '0)
                    cls_prefix = PFX_FIXSTR | operand[7:0];
                else if (operand[63:8] == '0)
                begin
                    cls_prefix = (action_t'(action) == ACT_STR_HDR) ? PFX_STR8 : PFX_BIN8;
                    cls_n      = 4'd1;
                end
                else if (operand[63:16] == '0)
                begin
                    cls_prefix = (action_t'(action) == ACT_STR_HDR) ? PFX_STR16 : PFX_BIN16;
                    cls_n      = 4'd2;
                end
                else if (operand[63:32] == '0)
                begin
                    cls_prefix = (action_t'(action) == ACT_STR_HDR) ? PFX_STR32 : PFX_BIN32;
                    cls_n      = 4'd4;
                end
                else
                begin
                    // length does not fit 32 bits
                    cls_prefix = PFX_ERROR;
                    cls_err    = 1'b1;
                end
            end
            ACT_RAW:     cls_prefix = operand[7:0];
            default:     known = 1'b0;
        endcase
    end

    // payload aligned to the top byte so the back end only shifts left
    always_comb
    begin
        wr_desc.prefix = cls_prefix;
        wr_desc.nbytes = cls_n;
        wr_desc.err    = cls_err;
        unique case (cls_n)
            4'd1:    wr_desc.payload = {operand[7:0], 56'b0};
            4'd2:    wr_desc.payload = {operand[15:0], 48'b0};
            4'd4:    wr_desc.payload = {operand[31:0], 32'b0};
            4'd8:    wr_desc.payload = operand;
            default: wr_desc.payload = '0;
        endcase
    end

    // unused action codes are taken and dropped
    assign wr_en = push && !full && known;

endmodule

/* rtl/core/mpse_queue.sv */
// short descriptor queue between front and back end
// depends on mpse_pkg
`timescale 1ns / 1ps

module mpse_queue
    import mpse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_desc,
    input  logic  rd_en,
    output desc_t rd_desc,
    output logic  q_full,
    output logic  q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_desc;
    end

endmodule

/* rtl/core/mpse_emit.sv */
// back end: sends one element as a run of byte beats
// depends on mpse_pkg
`timescale 1ns / 1ps

module mpse_emit
    import mpse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  desc_t             rd_desc,
    input  logic              q_empty,
    output logic              rd_en,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    output logic              error
);

    emit_state_t          state_reg;
    emit_state_t          state_next;
    logic [BYTE_W-1:0]    prefix_reg;
    logic [OPERAND_W-1:0] shift_reg;
    logic [NBYTES_W-1:0]  remain_reg;
    logic                 err_reg;
    logic                 take;
    logic                 load;

    // output decode
    always_comb
    begin
        empty    = 1'b0;
        out_byte = shift_reg[OPERAND_W-1 -: BYTE_W];
        last     = 1'b0;
        error    = 1'b0;
        unique case (state_reg)
            EMIT_IDLE:
                empty = 1'b1;
            EMIT_PREFIX:
            begin
                out_byte = prefix_reg;
                last     = (remain_reg == '0);
                error    = err_reg;
            end
            EMIT_PAYLOAD:
                last = (remain_reg == NBYTES_W'(1));
            default:
                empty = 1'b1;
        endcase
    end

    // next element may enter in the cycle the final beat leaves
    assign take  = (state_reg == EMIT_IDLE) || (pop && last);
    assign load  = take && !q_empty;
    assign rd_en = load;

    // next state
    always_comb
    begin
        state_next = state_reg;
        priority if (load)
            state_next = EMIT_PREFIX;
        else if (take)
            state_next = EMIT_IDLE;
        else if (pop && state_reg == EMIT_PREFIX)
            state_next = EMIT_PAYLOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= EMIT_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prefix_reg <= rd_desc.prefix;
            shift_reg  <= rd_desc.payload;
            remain_reg <= rd_desc.nbytes;
            err_reg    <= rd_desc.err;
        end
        else if (pop && state_reg == EMIT_PAYLOAD)
        begin
            shift_reg  <= {shift_reg[OPERAND_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            remain_reg <= remain_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/messagepack_scalar_encoder_unit.sv */
// top level of the messagepack scalar encoder
// depends on mpse_pkg, mpse_classify, mpse_queue, mpse_emit
`timescale 1ns / 1ps

// Each pushed request becomes one MessagePack element sent as byte beats, most
// significant first, with last on the final beat of the element. An element is the
// type byte plus 0, 1, 2, 4 or 8 payload bytes. The back-end serializer sends one
// byte per cycle while pop is high, so that serializer sets the sustained rate.
// Requests are taken every cycle while the QUEUE_DEPTH-entry descriptor queue has
// room, and a queued next element starts in the cycle after the previous final
// beat is popped. Action codes 9 to 15 are taken and give no beat. An oversized
// header length gives a single zero beat with error.
module messagepack_scalar_encoder_unit
    import mpse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [ACTION_W-1:0]  action,
    input  logic [OPERAND_W-1:0] operand,
    output logic                 empty,
    input  logic                 pop,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 last,
    output logic                 error
);

    logic  wr_en;
    desc_t wr_desc;
    logic  rd_en;
    desc_t rd_desc;
    logic  q_empty;

    mpse_classify u_classify (
        .push    (push),
        .full    (full),
        .action  (action),
        .operand (operand),
        .wr_en   (wr_en),
        .wr_desc (wr_desc)
    );

    mpse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_desc (wr_desc),
        .rd_en   (rd_en),
        .rd_desc (rd_desc),
        .q_full  (full),
        .q_empty (q_empty)
    );

    mpse_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_desc  (rd_desc),
        .q_empty  (q_empty),
        .rd_en    (rd_en),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

endmodule

/* rtl/core/mpse_checker.sv */
// port-level checks of the messagepack scalar encoder, bound to the top level
// depends on mpse_pkg, assert_macros.svh, messagepack_scalar_encoder_unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpse_checker
    import mpse_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [BYTE_W-1:0]    out_byte,
    input logic                 last,
    input logic                 error
);

    // nothing offered while in reset
    `AST_ALWAYS(a_reset_empty, clk, rst_n || empty)

    // an error beat is a lone zero beat
    `AST_SAME(a_error_beat, clk, rst_n, !empty && error, last && out_byte == '0)

    // the rest of an element follows without a gap
    `AST_NEXT(a_no_gap, clk, rst_n, !empty && pop && !last, !empty && !error)

    // a waiting beat holds
    `AST_NEXT(a_hold, clk, rst_n, !empty && !pop,
              !empty && $stable(out_byte) && $stable(last) && $stable(error))

endmodule

bind messagepack_scalar_encoder_unit mpse_checker u_mpse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .error    (error)
);

/* verif/mpse_stream_checker.sv */
// stream checker for the messagepack scalar encoder: predicts the byte beats of every
// accepted request and compares them with the beats popped from the block
// depends on mpse_pkg
`timescale 1ns / 1ps

module mpse_stream_checker
    import mpse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [ACTION_W-1:0]  action,
    input  logic [OPERAND_W-1:0] operand,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [BYTE_W-1:0]    out_byte,
    input  logic                 last,
    input  logic                 error,
    output int                   mismatches,
    output int                   pending
);

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic              err;
    } beat_t;

    beat_t expected_beats[$];
    int    beats_seen;

    initial
    begin
        mismatches = 0;
        pending    = 0;
        beats_seen = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: beat %0d: %s", $time, beats_seen, what);
        mismatches++;
    endtask

    // type byte, payload length and payload of one element, then queue its beats
    function automatic void encode_element(input logic [ACTION_W-1:0]  act,
                                           input logic [OPERAND_W-1:0] val);
        logic [BYTE_W-1:0] lead;
        int                n;
        logic              bad;
        logic              is_str;
        beat_t             b;
        lead   = PFX_NIL;
        n      = 0;
        bad    = 1'b0;
        is_str = (act == ACT_STR_HDR);
        case (act)
            ACT_NIL:     lead = PFX_NIL;
            ACT_BOOL:    lead = (val != '0) ? PFX_TRUE : PFX_FALSE;
            ACT_UINT:
            begin
                if (val <= 64'h7f)
                    lead = val[7:0];
                else if (val <= 64'hff)
                begin
                    lead = PFX_UINT8;
                    n = 1;
                end
                else if (val <= 64'hffff)
                begin
                    lead = PFX_UINT16;
                    n = 2;
                end
                else if (val <= 64'hffff_ffff)
                begin
                    lead = PFX_UINT32;
                    n = 4;
                end
                else
                begin
                    lead = PFX_UINT64;
                    n = 8;
                end
            end
            ACT_SINT:
            begin
                if (!val[63])
                begin
                    // positive values never take the one-byte signed form
                    if (val <= 64'h7f)
                        lead = val[7:0];
                    else if (val <= 64'h7fff)
                    begin
                        lead = PFX_INT16;
                        n = 2;
                    end
                    else if (val <= 64'h7fff_ffff)
                    begin
                        lead = PFX_INT32;
                        n = 4;
                    end
                    else
                    begin
                        lead = PFX_INT64;
                        n = 8;
                    end
                end
                else if (val >= 64'hffff_ffff_ffff_ffe0)
                    lead = val[7:0];
                else if (val >= 64'hffff_ffff_ffff_ff80)
                begin
                    lead = PFX_INT8;
                    n = 1;
                end
                else if (val >= 64'hffff_ffff_ffff_8000)
                begin
                    lead = PFX_INT16;
                    n = 2;
                end
                else if (val >= 64'hffff_ffff_8000_0000)
                begin
                    lead = PFX_INT32;
                    n = 4;
                end
                else
                begin
                    lead = PFX_INT64;
                    n = 8;
                end
            end
            ACT_FLOAT32:
            begin
                lead = PFX_FLOAT32;
                n = 4;
            end
            ACT_FLOAT64:
            begin
                lead = PFX_FLOAT64;
                n = 8;
            end
            ACT_STR_HDR, ACT_BIN_HDR:
            begin
                if (is_str && val <= 64'd31)
                    lead = PFX_FIXSTR | val[7:0];
                else if (val <= 64'hff)
                begin
                    lead = is_str ? PFX_STR8 : PFX_BIN8;
                    n = 1;
                end
                else if (val <= 64'hffff)
                begin
                    lead = is_str ? PFX_STR16 : PFX_BIN16;
                    n = 2;
                end
                else if (val <= 64'hffff_ffff)
                begin
                    lead = is_str ? PFX_STR32 : PFX_BIN32;
                    n = 4;
                end
                else
                begin
                    // length too wide for any header
                    lead = PFX_ERROR;
                    bad = 1'b1;
                end
            end
            ACT_RAW:     lead = val[7:0];
            default:     return;
        endcase
        b.data = lead;
        b.fin  = (n == 0);
        b.err  = bad;
        expected_beats.push_back(b);
        for (int i = n - 1; i >= 0; i--)
        begin
            b.data = val[8*i +: 8];
            b.fin  = (i == 0);
            b.err  = 1'b0;
            expected_beats.push_back(b);
        end
    endfunction

    always @(posedge clk)
    begin : watch_channels
        beat_t want;
        if (rst_n)
        begin
            // a beat popped now comes from an earlier request, so check before adding
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("unexpected beat %02h", out_byte));
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  out_byte, want.data));
                    if (last !== want.fin)
                        report_mismatch($sformatf("last %b, want %b", last, want.fin));
                    if (error !== want.err)
                        report_mismatch($sformatf("error %b, want %b", error, want.err));
                end
                beats_seen++;
            end
            if (push && !full)
                encode_element(action, operand);
        end
        pending <= expected_beats.size();
    end

endmodule

/* verif/tb_messagepack_scalar_encoder_unit.sv */
// testbench top for messagepack_scalar_encoder_unit: directed and random requests with
// random gaps on both sides; checking is left to mpse_stream_checker
// depends on mpse_pkg, mpse_stream_checker and the encoder rtl
`timescale 1ns / 1ps

module tb_messagepack_scalar_encoder_unit;
    import mpse_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;
    localparam int RANDOM_ITEMS = 320;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int SETTLE       = 30;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [ACTION_W-1:0]  action;
    logic [OPERAND_W-1:0] operand;
    logic                 empty;
    logic                 pop;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last;
    logic                 error;
    int                   mismatches;
    int                   pending;
    int                   cycle_count;
    bit                   no_idle;

    messagepack_scalar_encoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .action   (action),
        .operand  (operand),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

    mpse_stream_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .operand    (operand),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values clustered around the encoding boundaries, plus full-width noise
    function automatic logic [OPERAND_W-1:0] pick_value();
        logic [OPERAND_W-1:0] around;
        int                   k;
        k = $urandom_range(1, 63);
        around = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
        case ($urandom_range(0, 6))
            0: return 64'($urandom_range(0, 255));
            1: return 64'($urandom_range(0, 65535));
            2: return 64'($urandom);
            3: return {$urandom, $urandom};
            4: return around;
            5: return ~around;
            default: return -64'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0]  act,
                             input logic [OPERAND_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            push    <= 1'b0;
            action  <= 4'($urandom);
            operand <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        action  <= act;
        operand <= val;
        do
            @(posedge clk);
        while (full);
    endtask

    // result side: pop with random stalls
    initial
    begin : drain_beats
        int hold;
        hold = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!no_idle)
                    hold = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        logic [ACTION_W-1:0] act;
        no_idle = 1'b0;
        rst_n   = 1'b0;
        push    <= 1'b0;
        action  <= ACT_NIL;
        operand <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boundaries of the encodings and the special cases
        send_item(ACT_NIL,     {$urandom, $urandom});
        send_item(ACT_BOOL,    64'd0);
        send_item(ACT_BOOL,    64'h8000_0000_0000_0000);
        send_item(ACT_UINT,    64'h7f);
        send_item(ACT_UINT,    64'hff);
        send_item(ACT_UINT,    64'hffff);
        send_item(ACT_UINT,    64'hffff_ffff);
        send_item(ACT_UINT,    64'hffff_ffff_ffff_ffff);
        send_item(ACT_SINT,    64'h80);
        send_item(ACT_SINT,    64'h7fff_ffff_ffff_ffff);
        send_item(ACT_SINT,    -64'd32);
        send_item(ACT_SINT,    -64'd33);
        send_item(ACT_SINT,    -64'd129);
        send_item(ACT_SINT,    64'h8000_0000_0000_0000);
        send_item(ACT_FLOAT32, 64'hffff_ffff_1234_5678);
        send_item(ACT_FLOAT64, 64'hdead_beef_cafe_f00d);
        send_item(ACT_STR_HDR, 64'd31);
        send_item(ACT_STR_HDR, 64'd32);
        send_item(ACT_STR_HDR, 64'hffff_ffff);
        send_item(ACT_STR_HDR, 64'h1_0000_0000);
        send_item(ACT_BIN_HDR, 64'd0);
        send_item(ACT_BIN_HDR, 64'hffff_ffff_ffff_ffff);
        send_item(ACT_RAW,     64'hffff_ffff_ffff_ffa5);
        send_item(ACT_UNUSED_LO, {$urandom, $urandom});
        send_item(ACT_UNUSED_HI, {$urandom, $urandom});

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 5)
                act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            else
                act = 4'($urandom_range(ACT_NIL, ACT_RAW));
            send_item(act, pick_value());
        end
        no_idle = 1'b0;
        push <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
